// ===== src/shifting_array_list_unit_defines.svh =====
// Assertion macros for the shifting array list unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SHIFTING_ARRAY_LIST_UNIT_DEFINES_SVH
`define SHIFTING_ARRAY_LIST_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sal_pkg.sv =====
// Shared types and codes for the shifting array list unit.
// No dependencies; used by sal_cell, the top level and the testbench.
package sal_pkg;

    localparam int HW = 16;   // handle width
    localparam int PW = 6;    // position width
    localparam int CNTW = 7;  // count port width

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_READ      = 3'd1,
        CMD_OVERWRITE = 3'd2,
        CMD_INSERT    = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_REMOVE    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_WRITE,
        CELL_INSERT,
        CELL_CLEAR,
        CELL_REMOVE
    } cell_op_t;

    // broadcast to every cell in the row
    typedef struct packed {
        cell_op_t        op;
        logic [PW-1:0]   pos;
    } cell_ctl_t;

endpackage

// ===== src/shifting_array_list_unit.sv =====
// Top level of the shifting array list unit: control, size register, cell row.
// Depends on sal_pkg, sal_cell, sal_len_enc and shifting_array_list_unit_defines.svh.
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------
//  request   | start / busy     | cmd, position, handle_in
//  result    | done (strobe)    | handle_out, count, is_empty, status
//
// Each request runs through S_EXEC, the parallel shift/write across the cell
// row, then S_FIN, the size recompute by priority encode over the slots.
// busy is high only in the shift cycle; a request may be taken in the cycle
// the previous result is being finished. done pulses for one cycle.
// Reset clears every slot and the size at once; no sweep is needed.
// The receiver cannot stall; results are never held.
`include "shifting_array_list_unit_defines.svh"

module shifting_array_list_unit #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 cmd,
    input  logic [sal_pkg::PW-1:0]     position,
    input  logic [sal_pkg::HW-1:0]     handle_in,
    output logic                       done,
    output logic [sal_pkg::HW-1:0]     handle_out,
    output logic [sal_pkg::CNTW-1:0]   count,
    output logic                       is_empty,
    output logic [1:0]                 status
);

    localparam int LW = $clog2(DEPTH + 1);

    sal_pkg::state_t state_reg;
    sal_pkg::state_t state_next;

    logic accept;
    logic in_exec;
    logic in_fin;

    logic [2:0]                cmd_reg;
    logic [sal_pkg::PW-1:0]    pos_reg;
    logic [sal_pkg::HW-1:0]    hin_reg;
    logic [LW-1:0]             length_reg;
    logic [LW-1:0]             length_next;
    logic [sal_pkg::HW-1:0]    hout_reg;
    logic [sal_pkg::HW-1:0]    hout_next;
    logic [1:0]                stat_reg;
    logic [1:0]                stat_next;
    logic                      recomp_reg;
    logic                      recomp_next;

    logic                      done_reg;
    logic [sal_pkg::HW-1:0]    hout_out_reg;
    logic [sal_pkg::CNTW-1:0]  count_reg;
    logic                      empty_reg;
    logic [1:0]                status_reg;
    logic [LW-1:0]             final_len;

    sal_pkg::cell_ctl_t        ctl;
    logic                      pos_ok;
    logic                      pos_lt_len;
    logic                      full;

    logic [sal_pkg::HW-1:0]    slot_w [DEPTH];
    logic [sal_pkg::HW-1:0]    tap_w  [DEPTH];
    logic [DEPTH-1:0]          occ_w;
    logic [sal_pkg::HW-1:0]    tap_or;
    logic [LW-1:0]             enc_len;

    // ---------------- control FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sal_pkg::S_IDLE: state_next = start ? sal_pkg::S_EXEC : sal_pkg::S_IDLE;
            sal_pkg::S_EXEC: state_next = sal_pkg::S_FIN;
            sal_pkg::S_FIN:  state_next = start ? sal_pkg::S_EXEC : sal_pkg::S_IDLE;
            default:         state_next = sal_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_exec = 1'b0;
        in_fin  = 1'b0;
        case (state_reg)
            sal_pkg::S_EXEC: in_exec = 1'b1;
            sal_pkg::S_FIN:  in_fin  = 1'b1;
            default:
            begin
                in_exec = 1'b0;
                in_fin  = 1'b0;
            end
        endcase
    end

    assign busy   = in_exec;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sal_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            hin_reg <= handle_in;
        end
    end

    // ---------------- command decode ----------------
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
            tap_or = tap_or | tap_w[i];
    end

    always_comb
    begin
        pos_ok     = (int'(pos_reg) < DEPTH);
        pos_lt_len = (int'(pos_reg) < int'(length_reg));
        full       = (length_reg == LW'(DEPTH));

        ctl.op      = sal_pkg::CELL_HOLD;
        ctl.pos     = pos_reg;
        length_next = length_reg;
        hout_next   = '0;
        stat_next   = sal_pkg::STAT_OK;
        recomp_next = 1'b0;

        case (cmd_reg)
            sal_pkg::CMD_APPEND:
            begin
                if (full)
                    stat_next = sal_pkg::STAT_FULL;
                else
                begin
                    ctl.op      = sal_pkg::CELL_APPEND;
                    length_next = LW'(length_reg + 1'b1);
                    hout_next   = hin_reg;
                end
            end
            sal_pkg::CMD_READ:
            begin
                if (!pos_lt_len || !pos_ok)
                    stat_next = sal_pkg::STAT_RANGE;
                else
                    hout_next = tap_or;
            end
            sal_pkg::CMD_OVERWRITE:
            begin
                if (!pos_ok)
                    stat_next = sal_pkg::STAT_RANGE;
                else
                begin
                    ctl.op    = sal_pkg::CELL_WRITE;
                    hout_next = hin_reg;
                    if (int'(length_reg) < int'(pos_reg) + 1)
                        length_next = LW'(int'(pos_reg) + 1);
                end
            end
            sal_pkg::CMD_INSERT:
            begin
                if (!pos_ok)
                    stat_next = sal_pkg::STAT_RANGE;
                else if (full)
                    stat_next = sal_pkg::STAT_FULL;
                else
                begin
                    ctl.op      = sal_pkg::CELL_INSERT;
                    hout_next   = hin_reg;
                    recomp_next = 1'b1;
                end
            end
            sal_pkg::CMD_CLEAR:
            begin
                if (!pos_ok)
                    stat_next = sal_pkg::STAT_RANGE;
                else
                begin
                    ctl.op      = sal_pkg::CELL_CLEAR;
                    hout_next   = tap_or;
                    recomp_next = 1'b1;
                end
            end
            sal_pkg::CMD_REMOVE:
            begin
                if (!pos_ok)
                    stat_next = sal_pkg::STAT_RANGE;
                else if (pos_lt_len)
                begin
                    ctl.op      = sal_pkg::CELL_REMOVE;
                    hout_next   = tap_or;
                    recomp_next = 1'b1;
                end
            end
            default:
            begin
                ctl.op = sal_pkg::CELL_HOLD;
            end
        endcase

        // cells only move in the shift cycle
        if (!in_exec)
        begin
            ctl.op      = sal_pkg::CELL_HOLD;
            length_next = length_reg;
        end
        if (in_fin && recomp_reg)
            length_next = enc_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else
            length_reg <= length_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_exec)
        begin
            hout_reg   <= hout_next;
            stat_reg   <= stat_next;
            recomp_reg <= recomp_next;
        end
    end

    // ---------------- cell row ----------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [sal_pkg::HW-1:0] left_w;
        logic [sal_pkg::HW-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = slot_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = slot_w[g+1];
        end

        sal_cell #(
            .INDEX (g),
            .LW    (LW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .length (length_reg),
            .handle (hin_reg),
            .left   (left_w),
            .right  (right_w),
            .slot   (slot_w[g]),
            .tap    (tap_w[g]),
            .occ    (occ_w[g])
        );
    end

    sal_len_enc #(
        .DEPTH (DEPTH),
        .LW    (LW)
    ) u_len_enc (
        .occ (occ_w),
        .len (enc_len)
    );

    // ---------------- result ----------------
    assign final_len = recomp_reg ? enc_len : length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_fin;
    end

    always_ff @(posedge clk)
    begin
        if (in_fin)
        begin
            hout_out_reg <= hout_reg;
            count_reg    <= sal_pkg::CNTW'(final_len);
            empty_reg    <= (final_len == '0);
            status_reg   <= stat_reg;
        end
    end

    assign done       = done_reg;
    assign handle_out = hout_out_reg;
    assign count      = count_reg;
    assign is_empty   = empty_reg;
    assign status     = status_reg;

    // ---------------- checks ----------------
    `SAL_ASSERT_NEXT(a_fin_gives_done, (state_reg == sal_pkg::S_FIN), done, "finish without result strobe")
    `SAL_ASSERT_NOW(a_len_bounded, 1'b1, (length_reg <= LW'(DEPTH)), "list size above capacity")
    `SAL_ASSERT_NOW(a_err_no_handle, (done && status != sal_pkg::STAT_OK), (handle_out == '0), "handle on failed request")
    `SAL_ASSERT_NEXT(a_accept_exec, (start && !busy), (state_reg == sal_pkg::S_EXEC), "accepted request not executed")

endmodule

// ===== src/sal_cell.sv =====
// One slot of the list: holds a handle, shifts with its neighbors.
// Depends on sal_pkg.
module sal_cell #(
    parameter int INDEX = 0,
    parameter int LW = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sal_pkg::cell_ctl_t      ctl,
    input  logic [LW-1:0]           length,
    input  logic [sal_pkg::HW-1:0]  handle,
    input  logic [sal_pkg::HW-1:0]  left,
    input  logic [sal_pkg::HW-1:0]  right,
    output logic [sal_pkg::HW-1:0]  slot,
    output logic [sal_pkg::HW-1:0]  tap,
    output logic                    occ
);

    logic [sal_pkg::HW-1:0] slot_reg;
    logic [sal_pkg::HW-1:0] slot_next;
    logic at_pos;
    logic above_pos;
    logic at_len;
    logic upto_len;
    logic is_last;
    logic below_last;

    always_comb
    begin
        at_pos     = (INDEX == int'(ctl.pos));
        above_pos  = (INDEX > int'(ctl.pos));
        at_len     = (INDEX == int'(length));
        upto_len   = (INDEX <= int'(length));
        is_last    = (INDEX + 1 == int'(length));
        below_last = (INDEX + 1 < int'(length));
    end

    always_comb
    begin
        slot_next = slot_reg;
        case (ctl.op)
            sal_pkg::CELL_APPEND:
            begin
                if (at_len)
                    slot_next = handle;
            end
            sal_pkg::CELL_WRITE:
            begin
                if (at_pos)
                    slot_next = handle;
            end
            sal_pkg::CELL_INSERT:
            begin
                // shift up over pos+1..length
                if (at_pos)
                    slot_next = handle;
                else if (above_pos && upto_len)
                    slot_next = left;
            end
            sal_pkg::CELL_CLEAR:
            begin
                if (at_pos)
                    slot_next = '0;
            end
            sal_pkg::CELL_REMOVE:
            begin
                // shift down over pos..length-2, vacate length-1
                if (!above_pos && !at_pos)
                    slot_next = slot_reg;
                else if (below_last)
                    slot_next = right;
                else if (is_last)
                    slot_next = '0;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot = slot_reg;
    assign tap  = at_pos ? slot_reg : '0;
    assign occ  = (slot_reg != '0);

endmodule

// ===== src/sal_len_enc.sv =====
// Size recompute: index of the highest occupied slot plus one.
// Depends on nothing but its parameters.
module sal_len_enc #(
    parameter int DEPTH = 64,
    parameter int LW = 7
) (
    input  logic [DEPTH-1:0] occ,
    output logic [LW-1:0]    len
);

    always_comb
    begin
        len = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (occ[i])
                len = LW'(i + 1);
        end
    end

endmodule

// ===== test/tb_shifting_array_list_unit.sv =====
// Self-checking testbench for shifting_array_list_unit: directed corner cases, then
// random command streams, checked against an in-bench model of the handle list.
// Depends on sal_pkg and the shifting_array_list_unit RTL.
module tb_shifting_array_list_unit;

    localparam int SLOTS = 64;
    localparam int RANDOM_REQUESTS = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 6;

    // command codes the block decodes as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct {
        logic [sal_pkg::HW-1:0]   handle;
        logic [sal_pkg::CNTW-1:0] size;
        logic                     empty;
        logic [1:0]               code;
    } list_result_t;

    class handle_list_model;
        logic [sal_pkg::HW-1:0] slots [SLOTS];
        int            length;
        list_result_t  pending_results [$];
        int            requests;
        int            checked;
        int            mismatches;
        int            orphans;
        int            full_hits;
        int            range_hits;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            length = 0;
            requests = 0;
            checked = 0;
            mismatches = 0;
            orphans = 0;
            full_hits = 0;
            range_hits = 0;
        endfunction

        // size = last occupied slot + 1
        function void settle_length();
            int i;
            length = 0;
            for (i = 0; i < SLOTS; i++)
                if (slots[i] != '0)
                    length = i + 1;
        endfunction

        function void note_request(input logic [2:0] op, input logic [sal_pkg::PW-1:0] pos,
                                   input logic [sal_pkg::HW-1:0] h);
            list_result_t r;
            int i;
            int p;
            p = int'(pos);
            r.handle = '0;
            r.code = sal_pkg::STAT_OK;
            // a 6-bit position never reaches the 64-slot capacity
            case (op)
                sal_pkg::CMD_APPEND:
                    if (length >= SLOTS)
                        r.code = sal_pkg::STAT_FULL;
                    else
                    begin
                        slots[length] = h;
                        length++;
                        r.handle = h;
                    end
                sal_pkg::CMD_READ:
                    if (p >= length)
                        r.code = sal_pkg::STAT_RANGE;
                    else
                        r.handle = slots[p];
                sal_pkg::CMD_OVERWRITE:
                begin
                    slots[p] = h;
                    if (length < p + 1)
                        length = p + 1;
                    r.handle = h;
                end
                sal_pkg::CMD_INSERT:
                    if (length >= SLOTS)
                        r.code = sal_pkg::STAT_FULL;
                    else
                    begin
                        for (i = length; i > p; i--)
                            slots[i] = slots[i - 1];
                        slots[p] = h;
                        settle_length();
                        r.handle = h;
                    end
                sal_pkg::CMD_CLEAR:
                begin
                    r.handle = slots[p];
                    slots[p] = '0;
                    settle_length();
                end
                sal_pkg::CMD_REMOVE:
                    if (p < length)
                    begin
                        r.handle = slots[p];
                        for (i = p; i + 1 < length; i++)
                            slots[i] = slots[i + 1];
                        slots[length - 1] = '0;
                        settle_length();
                    end
                default:
                    ;
            endcase
            r.size = length[sal_pkg::CNTW-1:0];
            r.empty = (length == 0);
            if (r.code == sal_pkg::STAT_FULL)
                full_hits++;
            if (r.code == sal_pkg::STAT_RANGE)
                range_hits++;
            requests++;
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic [sal_pkg::HW-1:0] h,
                                   input logic [sal_pkg::CNTW-1:0] c,
                                   input logic e, input logic [1:0] s);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                orphans++;
                if (mismatches + orphans <= REPORT_LIMIT)
                    $display("ERROR: result with no request outstanding: handle %h count %0d",
                             h, c);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (h !== want.handle || c !== want.size || e !== want.empty ||
                    s !== want.code)
                begin
                    mismatches++;
                    if (mismatches + orphans <= REPORT_LIMIT)
                    begin
                        $write("ERROR: result %0d: handle %h/%h count %0d/%0d ",
                               checked, want.handle, h, want.size, c);
                        $display("empty %b/%b status %0d/%0d (expected/actual)",
                                 want.empty, e, want.code, s);
                    end
                end
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               cmd;
    logic [sal_pkg::PW-1:0]   position;
    logic [sal_pkg::HW-1:0]   handle_in;
    logic                     done;
    logic [sal_pkg::HW-1:0]   handle_out;
    logic [sal_pkg::CNTW-1:0] count;
    logic                     is_empty;
    logic [1:0]               status;

    handle_list_model model = new();
    int  cycles = 0;
    bit  steady = 1'b0;

    shifting_array_list_unit #(.DEPTH(SLOTS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .position   (position),
        .handle_in  (handle_in),
        .done       (done),
        .handle_out (handle_out),
        .count      (count),
        .is_empty   (is_empty),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, model.pending_results.size());
            $display("shifting_array_list_unit regression: fail");
            $finish;
        end
    end

    // result first: a result at this edge belongs to an earlier request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                model.check_result(handle_out, count, is_empty, status);
            if (start && !busy)
                model.note_request(cmd, position, handle_in);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [sal_pkg::HW-1:0] pick_handle();
        logic [sal_pkg::HW-1:0] v;
        v = sal_pkg::HW'($urandom);
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // mostly a position within the list size, otherwise anywhere
    function automatic logic [sal_pkg::PW-1:0] pick_position();
        if (model.length > 0 && $urandom_range(0, 3) != 0)
            return sal_pkg::PW'($urandom_range(0, model.length - 1));
        return sal_pkg::PW'($urandom_range(0, SLOTS - 1));
    endfunction

    // entered and left at a falling edge; start stays high across back-to-back requests
    task automatic send_request(input logic [2:0] op, input logic [sal_pkg::PW-1:0] pos,
                                input logic [sal_pkg::HW-1:0] h);
        int gap;
        cmd = op;
        position = pos;
        handle_in = h;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (model.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        send_request(sal_pkg::CMD_READ, 6'd0, 16'h1111);         // read of empty list
        send_request(sal_pkg::CMD_REMOVE, 6'd0, 16'h0000);       // remove beyond size
        send_request(sal_pkg::CMD_CLEAR, 6'd0, 16'h0000);
        send_request(sal_pkg::CMD_APPEND, 6'd0, 16'hFFFF);
        send_request(sal_pkg::CMD_APPEND, 6'd63, 16'h0000);      // empty handle still grows size
        send_request(sal_pkg::CMD_APPEND, 6'd0, 16'h0001);
        send_request(sal_pkg::CMD_READ, 6'd0, 16'h0000);
        send_request(sal_pkg::CMD_READ, 6'd2, 16'h0000);
        send_request(sal_pkg::CMD_READ, 6'd3, 16'h0000);
        send_request(sal_pkg::CMD_OVERWRITE, 6'd63, 16'hFFFF);   // fills the list
        send_request(sal_pkg::CMD_APPEND, 6'd0, 16'h2222);
        send_request(sal_pkg::CMD_INSERT, 6'd5, 16'h3333);
        send_request(sal_pkg::CMD_READ, 6'd63, 16'h0000);
        send_request(sal_pkg::CMD_CLEAR, 6'd63, 16'h0000);
        send_request(sal_pkg::CMD_OVERWRITE, 6'd10, 16'h0000);   // empty slot, size still grows to 11
        send_request(sal_pkg::CMD_INSERT, 6'd1, 16'hAAAA);
        send_request(sal_pkg::CMD_INSERT, 6'd40, 16'h5555);      // past the end, no shift
        send_request(sal_pkg::CMD_REMOVE, 6'd0, 16'h0000);
        send_request(sal_pkg::CMD_REMOVE, 6'd50, 16'h0000);
        send_request(CMD_SPARE_A, 6'd3, 16'hBEEF);
        send_request(CMD_SPARE_B, 6'd63, 16'hFFFF);
        send_request(sal_pkg::CMD_INSERT, 6'd63, 16'h1234);
        send_request(sal_pkg::CMD_REMOVE, 6'd63, 16'h0000);
        send_request(sal_pkg::CMD_INSERT, 6'd0, 16'h0000);
        send_request(sal_pkg::CMD_CLEAR, 6'd1, 16'h0000);
    endtask

    task automatic run_random();
        int n;
        int k;
        int burst;
        n = 0;
        while (n < RANDOM_REQUESTS)
        begin
            steady = (n % 100) >= 80;
            if (n % 125 == 124)
                drain_results();
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                send_request(3'($urandom_range(0, 7)), sal_pkg::PW'($urandom),
                             sal_pkg::HW'($urandom));
                n++;
            end
            else if (k < 30)
            begin
                // now and then a run of appends toward a full list
                burst = ($urandom_range(0, 11) == 0) ? SLOTS - model.length + 1 : 1;
                repeat (burst)
                begin
                    send_request(sal_pkg::CMD_APPEND, sal_pkg::PW'($urandom), pick_handle());
                    n++;
                end
            end
            else if (k < 40)
            begin
                send_request(sal_pkg::CMD_READ, pick_position(), sal_pkg::HW'($urandom));
                n++;
            end
            else if (k < 50)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(sal_pkg::CMD_OVERWRITE, sal_pkg::PW'(SLOTS - 1),
                                 pick_handle());
                else
                    send_request(sal_pkg::CMD_OVERWRITE, pick_position(), pick_handle());
                n++;
            end
            else if (k < 65)
            begin
                send_request(sal_pkg::CMD_INSERT, pick_position(), pick_handle());
                n++;
            end
            else if (k < 75)
            begin
                send_request(sal_pkg::CMD_CLEAR, pick_position(), sal_pkg::HW'($urandom));
                n++;
            end
            else if (k < 95)
            begin
                send_request(sal_pkg::CMD_REMOVE, pick_position(), sal_pkg::HW'($urandom));
                n++;
            end
            else
                send_request($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                             sal_pkg::PW'($urandom), sal_pkg::HW'($urandom));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int failures;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = sal_pkg::CMD_APPEND;
        position = '0;
        handle_in = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        drain_results();
        run_random();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        failures = model.mismatches + model.orphans + model.pending_results.size();
        $display("%0d requests sent, %0d results checked, %0d mismatches, %0d stray results",
                 model.requests, model.checked, model.mismatches, model.orphans);
        $display("list-full answers: %0d, out-of-range answers: %0d",
                 model.full_hits, model.range_hits);
        if (failures == 0)
            $display("shifting_array_list_unit regression: pass");
        else
            $display("shifting_array_list_unit regression: fail");
        $finish;
    end
endmodule
